// File: hw/rtl/aoc_pkg.sv
package aoc_pkg;

   localparam int PIX_W      = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 14;
   localparam int POS_W      = 14;
   localparam int SIZE_W     = 13;
   localparam int GALPHA_W   = 9;

   localparam logic [CSR_IDX_W-1:0] CSR_OVERLAY_X      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OVERLAY_Y      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OVERLAY_WIDTH  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_OVERLAY_HEIGHT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_GLOBAL_ALPHA   = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_ALPHA_LAST     = 3'd7;

   localparam logic [GALPHA_W-1:0] ALPHA_ONE    = 9'd256;
   localparam logic [7:0]          ALPHA_OPAQUE = 8'hff;

   typedef struct packed {
      logic signed [POS_W-1:0] overlay_x;
      logic signed [POS_W-1:0] overlay_y;
      logic [SIZE_W-1:0]       overlay_width;
      logic [SIZE_W-1:0]       overlay_height;
      logic [SIZE_W-1:0]       frame_width;
      logic [SIZE_W-1:0]       frame_height;
      logic [GALPHA_W-1:0]     global_alpha;
      logic                    alpha_last;
   } cfg_type;

   // one classified pixel on its way from front to back
   typedef struct packed {
      logic [PIX_W-1:0] frame_pixel;
      logic [PIX_W-1:0] overlay_pixel;
      logic             in_overlay;
      logic             blend;
      logic             frame_end;
   } item_type;

endpackage

// File: hw/rtl/aoc_csr.sv
module aoc_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write,
   input  logic [aoc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [aoc_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output aoc_pkg::cfg_type                cfg
);
   import aoc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_OVERLAY_X:      cfg_in.overlay_x      = signed'(csr_wdata[POS_W-1:0]);
            CSR_OVERLAY_Y:      cfg_in.overlay_y      = signed'(csr_wdata[POS_W-1:0]);
            CSR_OVERLAY_WIDTH:  cfg_in.overlay_width  = csr_wdata[SIZE_W-1:0];
            CSR_OVERLAY_HEIGHT: cfg_in.overlay_height = csr_wdata[SIZE_W-1:0];
            CSR_FRAME_WIDTH:    cfg_in.frame_width    = csr_wdata[SIZE_W-1:0];
            CSR_FRAME_HEIGHT:   cfg_in.frame_height   = csr_wdata[SIZE_W-1:0];
            CSR_GLOBAL_ALPHA:   cfg_in.global_alpha   = csr_wdata[GALPHA_W-1:0];
            CSR_ALPHA_LAST:     cfg_in.alpha_last     = csr_wdata[0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.overlay_x      <= '0;
         cfg_ff.overlay_y      <= '0;
         cfg_ff.overlay_width  <= '0;
         cfg_ff.overlay_height <= '0;
         cfg_ff.frame_width    <= SIZE_W'(1);
         cfg_ff.frame_height   <= SIZE_W'(1);
         cfg_ff.global_alpha   <= ALPHA_ONE;
         cfg_ff.alpha_last     <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: hw/rtl/aoc_front.sv
module aoc_front #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                        clock,
   input  logic                        reset,
   input  aoc_pkg::cfg_type            cfg,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [aoc_pkg::PIX_W-1:0]   req_frame_pixel,
   input  logic [aoc_pkg::PIX_W-1:0]   req_overlay_pixel,
   input  logic                        q_full,
   output logic                        q_push,
   output aoc_pkg::item_type           q_push_item
);
   import aoc_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);
   localparam int MW = (CW > RW) ? CW : RW;
   // geometry math width: covers counters, sizes and sign
   localparam int GW = (MW + 2 > 16) ? MW + 2 : 16;

   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;

   logic [GW-1:0]        fw, fh;
   logic signed [GW-1:0] col_s, row_s;
   logic signed [GW-1:0] x_start, x_end, y_start, y_end;
   logic                 in_x, in_y, in_ov, row_end, frm_end, g_nonzero;

   always_comb begin
      priority if (cfg.frame_width == '0)
         fw = GW'(1);
      else if (GW'(cfg.frame_width) > GW'(MAX_WIDTH))
         fw = GW'(MAX_WIDTH);
      else
         fw = GW'(cfg.frame_width);

      priority if (cfg.frame_height == '0)
         fh = GW'(1);
      else if (GW'(cfg.frame_height) > GW'(MAX_HEIGHT))
         fh = GW'(MAX_HEIGHT);
      else
         fh = GW'(cfg.frame_height);
   end

   always_comb begin
      col_s   = signed'(GW'(col_ff));
      row_s   = signed'(GW'(row_ff));
      x_start = GW'(cfg.overlay_x);
      y_start = GW'(cfg.overlay_y);
      x_end   = x_start + signed'(GW'(cfg.overlay_width));
      y_end   = y_start + signed'(GW'(cfg.overlay_height));
      in_x    = (col_s >= x_start) && (col_s < x_end) && (GW'(col_ff) < fw);
      in_y    = (row_s >= y_start) && (row_s < y_end) && (GW'(row_ff) < fh);
      in_ov   = in_x && in_y;
      row_end = (GW'(col_ff) + GW'(1)) >= fw;
      frm_end = row_end && ((GW'(row_ff) + GW'(1)) >= fh);
      g_nonzero = cfg.global_alpha != '0;
   end

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

   always_comb begin
      q_push_item.frame_pixel   = req_frame_pixel;
      q_push_item.overlay_pixel = req_overlay_pixel;
      q_push_item.in_overlay    = in_ov;
      q_push_item.blend         = in_ov && g_nonzero;
      q_push_item.frame_end     = frm_end;
   end

   // counters past a shrunken frame size wrap on the next beat
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (q_push) begin
         if (row_end) begin
            col_in = '0;
            row_in = frm_end ? '0 : row_ff + RW'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

// File: hw/rtl/aoc_queue.sv
module aoc_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  aoc_pkg::item_type  push_item,
   output logic               full,
   input  logic               pop,
   output logic               pop_valid,
   output aoc_pkg::item_type  pop_item
);
   import aoc_pkg::*;

   // two-entry queue
   item_type    slot0_ff, slot1_ff;
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;

   assign full      = count_ff == 2'd2;
   assign pop_valid = count_ff != 2'd0;
   assign pop_item  = rd_ptr_ff ? slot1_ff : slot0_ff;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push && !wr_ptr_ff) slot0_ff <= push_item;
      if (push &&  wr_ptr_ff) slot1_ff <= push_item;
   end

endmodule

// File: hw/rtl/aoc_back.sv
module aoc_back (
   input  logic                        clock,
   input  logic                        reset,
   input  aoc_pkg::cfg_type            cfg,
   input  logic                        q_valid,
   input  aoc_pkg::item_type           q_item,
   output logic                        q_pop,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [aoc_pkg::PIX_W-1:0]   rsp_pixel_out,
   output logic                        rsp_in_overlay,
   output logic                        rsp_frame_end
);
   import aoc_pkg::*;

   logic                s1_valid_ff;
   item_type            s1_item_ff;
   logic [7:0]          s1_alpha_ff, s1_alpha_in;

   logic                out_valid_ff;
   logic [PIX_W-1:0]    out_pixel_ff, out_pixel_in;
   logic                out_in_ov_ff, out_frm_end_ff;

   logic                out_ready, s1_ready;
   logic [GALPHA_W-1:0] g_sat;
   logic [7:0]          ovl_alpha;
   logic [16:0]         alpha_prod;
   logic [GALPHA_W-1:0] inv_alpha;
   logic [16:0]         mix_sum [4];
   logic [7:0]          d_byte  [4];
   logic [7:0]          s_byte  [4];
   logic                is_alpha[4];

   assign out_ready = !out_valid_ff || !rsp_stall;
   assign s1_ready  = !s1_valid_ff || out_ready;
   assign q_pop     = q_valid && s1_ready;

   // stage 1: effective alpha
   always_comb begin
      g_sat       = (cfg.global_alpha > ALPHA_ONE) ? ALPHA_ONE : cfg.global_alpha;
      ovl_alpha   = cfg.alpha_last ? q_item.overlay_pixel[7:0] : q_item.overlay_pixel[31:24];
      alpha_prod  = 17'(ovl_alpha) * 17'(g_sat);
      s1_alpha_in = alpha_prod[15:8];
   end

   // stage 2: per-byte blend with the alpha byte forced opaque, or frame pixel unchanged when not blending
   always_comb begin
      inv_alpha    = ALPHA_ONE - GALPHA_W'(s1_alpha_ff);
      out_pixel_in = s1_item_ff.frame_pixel;
      for (int k = 0; k < 4; k++) begin
         d_byte[k]   = s1_item_ff.frame_pixel[k*8 +: 8];
         s_byte[k]   = s1_item_ff.overlay_pixel[k*8 +: 8];
         is_alpha[k] = cfg.alpha_last ? (k == 0) : (k == 3);
         mix_sum[k]  = 17'(d_byte[k]) * 17'(inv_alpha) + 17'(s_byte[k]) * 17'(s1_alpha_ff);
         if (s1_item_ff.blend)
            out_pixel_in[k*8 +: 8] = is_alpha[k] ? ALPHA_OPAQUE : mix_sum[k][15:8];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (s1_ready)  s1_valid_ff  <= q_valid;
         if (out_ready) out_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         s1_item_ff  <= q_item;
         s1_alpha_ff <= s1_alpha_in;
      end
      if (out_ready && s1_valid_ff) begin
         out_pixel_ff   <= out_pixel_in;
         out_in_ov_ff   <= s1_item_ff.in_overlay;
         out_frm_end_ff <= s1_item_ff.frame_end;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_pixel_out  = out_pixel_ff;
   assign rsp_in_overlay = out_in_ov_ff;
   assign rsp_frame_end  = out_frm_end_ff;

endmodule

// File: hw/rtl/argb_overlay_alpha_compositor.sv
// Path of a beat: queue write at the edge that accepts it, then alpha multiply stage,
//   then blend stage into the output register.
// Throughput: 1 beat per cycle; a stalled output backs up through the two-entry
//   queue, and req_stall rises when that queue is full.
// Reset (synchronous, active high): counters to column 0 / row 0, queue and
//   pipeline emptied, registers to their defaults (frame 1x1, global alpha 256).
module argb_overlay_alpha_compositor #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [aoc_pkg::PIX_W-1:0]       req_frame_pixel,
   input  logic [aoc_pkg::PIX_W-1:0]       req_overlay_pixel,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [aoc_pkg::PIX_W-1:0]       rsp_pixel_out,
   output logic                            rsp_in_overlay,
   output logic                            rsp_frame_end,
   input  logic                            csr_write,
   input  logic [aoc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [aoc_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import aoc_pkg::*;

   cfg_type  cfg;
   logic     q_full, q_push, q_pop, q_valid;
   item_type q_push_item, q_item;

   aoc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   aoc_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_frame_pixel   (req_frame_pixel),
      .req_overlay_pixel (req_overlay_pixel),
      .q_full            (q_full),
      .q_push            (q_push),
      .q_push_item       (q_push_item)
   );

   aoc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_push_item),
      .full      (q_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_item  (q_item)
   );

   aoc_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .q_valid        (q_valid),
      .q_item         (q_item),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_pixel_out  (rsp_pixel_out),
      .rsp_in_overlay (rsp_in_overlay),
      .rsp_frame_end  (rsp_frame_end)
   );

endmodule
